// ===== src/stst_pkg.sv =====
package stst_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int SW = 16;
    localparam int EW = 18;
    localparam int IW = 10;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // register select is paddr[2]
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_ENTRIES   = 1'b1;

    localparam logic [SW-1:0] TOL_RESET = 16'd16;

    typedef struct packed {
        logic [SW-1:0] one;
        logic [SW-1:0] two;
        logic [SW-1:0] three;
    } tri_t;

    typedef struct packed {
        logic          clear;
        logic          valid;
        logic [CW-1:0] idx;
    } scan_ctrl_t;

    typedef struct packed {
        logic          busy;
        logic          found;
        logic [CW-1:0] idx;
        logic [EW-1:0] err;
    } scan_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BS_ISSUE,
        ST_BS_CMP,
        ST_SCAN,
        ST_DRAIN
    } state_t;

endpackage

// ===== src/stst_store.sv =====
module stst_store (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [stst_pkg::AW-1:0]    wr_addr,
    input  stst_pkg::tri_t             wr_data,
    input  logic [stst_pkg::AW-1:0]    rd_addr,
    output stst_pkg::tri_t             rd_data
);
    import stst_pkg::*;

    tri_t mem [TABLE_DEPTH];
    tri_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/stst_scan.sv =====
// Three cells in a row: difference cell, sum cell, best-keep cell.
module stst_scan (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  stst_pkg::scan_ctrl_t    ctrl,
    input  stst_pkg::tri_t          entry,
    input  stst_pkg::tri_t          meas,
    input  logic [stst_pkg::SW-1:0] tol,
    output stst_pkg::scan_stat_t    stat
);
    import stst_pkg::*;

    logic          a_v_reg, a_v_next;
    logic [CW-1:0] a_idx_reg;
    logic [SW-1:0] e1_reg, e2_reg, e3_reg;
    logic          a_ok_reg;
    logic          b_v_reg, b_v_next;
    logic [CW-1:0] b_idx_reg;
    logic [EW-1:0] b_err_reg;
    logic          b_ok_reg;
    logic          best_found_reg, best_found_next;
    logic [CW-1:0] best_idx_reg, best_idx_next;
    logic [EW-1:0] best_err_reg, best_err_next;
    logic [SW-1:0] e1, e2, e3;
    logic          take;

    always_comb begin
        e1 = (entry.one   >= meas.one)   ? entry.one   - meas.one   : meas.one   - entry.one;
        e2 = (entry.two   >= meas.two)   ? entry.two   - meas.two   : meas.two   - entry.two;
        e3 = (entry.three >= meas.three) ? entry.three - meas.three : meas.three - entry.three;
        a_v_next = ctrl.valid;
        b_v_next = a_v_reg;
        take = b_v_reg && b_ok_reg && (!best_found_reg || (b_err_reg < best_err_reg));
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_err_next   = best_err_reg;
        if (ctrl.clear) begin
            best_found_next = 1'b0;
            best_idx_next   = '0;
            best_err_next   = '0;
        end else if (take) begin
            best_found_next = 1'b1;
            best_idx_next   = b_idx_reg;
            best_err_next   = b_err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg        <= 1'b0;
            b_v_reg        <= 1'b0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_err_reg   <= '0;
        end else begin
            a_v_reg        <= a_v_next;
            b_v_reg        <= b_v_next;
            best_found_reg <= best_found_next;
            best_idx_reg   <= best_idx_next;
            best_err_reg   <= best_err_next;
        end
        a_idx_reg <= ctrl.idx;
        e1_reg    <= e1;
        e2_reg    <= e2;
        e3_reg    <= e3;
        a_ok_reg  <= (e2 < tol) && (e3 < tol);
        b_idx_reg <= a_idx_reg;
        b_err_reg <= EW'(e1_reg) + EW'(e2_reg) + EW'(e3_reg);
        b_ok_reg  <= a_ok_reg;
    end

    assign stat.busy  = a_v_reg | b_v_reg;
    assign stat.found = best_found_reg;
    assign stat.idx   = best_idx_reg;
    assign stat.err   = best_err_reg;

endmodule

// ===== src/star_triangle_tolerance_match.sv =====
// Star triangle matcher.
// Input stream (s_): a beat with s_tuser = 0 loads one table entry at
// entry_index; s_tuser = 1 runs a query on the three measured sides. A load
// gives no result. A query gives one result beat on m_: m_tuser is the
// found flag, m_tdata carries the index of the best entry and its error.
// A query runs a binary search of ceil(log2(count+1)) steps, each step one
// table read (ST_BS_ISSUE) and one compare (ST_BS_CMP), then the scan of
// the tolerance window at one entry per cycle, then the scan cells drain.
// One query is worked at a time and s_tready is high only between items.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver still stalls when the next query finishes, that
// query holds in its drain step until the register frees up.
// Reset: tolerance 16, entries_in_use 0; table content is unknown until loaded.
// Registers over APB: 0x0 tolerance, 0x4 entries_in_use.
module star_triangle_tolerance_match (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // entry_index, side_one, side_two, side_three, pad
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // match_index, match_error, pad
    output logic [0:0]  m_tuser,   // found
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import stst_pkg::*;

    state_t        state_reg, state_next;
    logic [SW-1:0] tol_reg, tol_next;
    logic [CW-1:0] entries_reg, entries_next;
    tri_t          meas_reg;
    logic [SW-1:0] key_reg;
    logic [SW:0]   limit_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] base_reg, base_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          dv_reg, dv_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_found_reg;
    logic [IW-1:0] m_idx_reg;
    logic [EW-1:0] m_err_reg;

    logic          s_acc, cfg_wr, halt, issue, load_out;
    logic [CW-1:0] mid, cnt_clamp;
    logic [AW-1:0] rd_addr;
    tri_t          in_tri, rdata;
    scan_ctrl_t    ctrl;
    scan_stat_t    stat;

    assign s_acc  = s_tvalid && s_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRIES) ? {21'd0, entries_reg} : {16'd0, tol_reg};

    assign in_tri.one   = s_tdata[25:10];
    assign in_tri.two   = s_tdata[41:26];
    assign in_tri.three = s_tdata[57:42];
    assign cnt_clamp = (entries_reg > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : entries_reg;

    assign mid   = base_reg + (n_reg >> 1);
    assign halt  = dv_reg && ({1'b0, rdata.one} >= limit_reg);
    assign issue = (state_reg == ST_SCAN) && !halt && (rd_idx_reg < count_reg);
    assign rd_addr = (state_reg == ST_SCAN) ? rd_idx_reg[AW-1:0] : mid[AW-1:0];
    assign load_out = (state_reg == ST_DRAIN) && !stat.busy && (!m_valid_reg || m_tready);

    stst_store u_store (
        .aclk    (aclk),
        .wr_en   (s_acc && (s_tuser[0] == MODE_LOAD)),
        .wr_addr (s_tdata[AW-1:0]),
        .wr_data (in_tri),
        .rd_addr (rd_addr),
        .rd_data (rdata)
    );

    assign ctrl.clear = s_acc && (s_tuser[0] == MODE_QUERY);
    assign ctrl.valid = (state_reg == ST_SCAN) && dv_reg && !halt;
    assign ctrl.idx   = rd_idx_reg - CW'(1);

    stst_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .entry   (rdata),
        .meas    (meas_reg),
        .tol     (tol_reg),
        .stat    (stat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser[0] == MODE_QUERY)) begin
                    state_next = ST_BS_ISSUE;
                end
            end
            ST_BS_ISSUE: state_next = (n_reg == '0) ? ST_SCAN : ST_BS_CMP;
            ST_BS_CMP:   state_next = ST_BS_ISSUE;
            ST_SCAN:     state_next = issue ? ST_SCAN : ST_DRAIN;
            ST_DRAIN:    state_next = load_out ? ST_IDLE : ST_DRAIN;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        base_next    = base_reg;
        n_next       = n_reg;
        rd_idx_next  = rd_idx_reg;
        dv_next      = 1'b0;
        tol_next     = tol_reg;
        entries_next = entries_reg;
        m_valid_next = m_valid_reg;
        if (cfg_wr) begin
            if (paddr[2] == REG_TOLERANCE) tol_next = pwdata[SW-1:0];
            else                           entries_next = pwdata[CW-1:0];
        end
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        if (load_out) m_valid_next = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                base_next = '0;
                n_next    = cnt_clamp;
            end
            ST_BS_ISSUE: rd_idx_next = base_reg;
            ST_BS_CMP: begin
                if (rdata.one < key_reg) begin
                    base_next = mid + CW'(1);
                    n_next    = n_reg - (n_reg >> 1) - CW'(1);
                end else begin
                    n_next    = n_reg >> 1;
                end
            end
            ST_SCAN: begin
                dv_next = issue;
                if (issue) rd_idx_next = rd_idx_reg + CW'(1);
            end
            ST_DRAIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tol_reg     <= TOL_RESET;
            entries_reg <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tol_reg     <= tol_next;
            entries_reg <= entries_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
        end
        base_reg   <= base_next;
        n_reg      <= n_next;
        rd_idx_reg <= rd_idx_next;
        if (state_reg == ST_IDLE) begin
            meas_reg  <= in_tri;
            key_reg   <= (in_tri.one > tol_reg) ? in_tri.one - tol_reg : '0;
            limit_reg <= {1'b0, in_tri.one} + {1'b0, tol_reg};
            count_reg <= cnt_clamp;
        end
        if (load_out) begin
            m_found_reg <= stat.found;
            m_idx_reg   <= stat.idx[IW-1:0];
            m_err_reg   <= stat.err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {4'd0, m_err_reg, m_idx_reg};

    a_search_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BS_ISSUE) |-> ((base_reg + n_reg) <= count_reg))
        else $error("search window beyond count");
    a_no_match_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("no-match result carries data");
    a_idle_chain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !stat.busy)
        else $error("scan cells busy while idle");
    a_scan_read_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg |-> (rd_idx_reg <= count_reg))
        else $error("scan read past count");

endmodule
